@@ rtl/core/fmqd_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// FM quadrature demodulator package
// Shared angle, gain and output types, and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package fmqd_pkg;

    localparam int ANGLE_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int OUT_W      = 16;
    localparam int GAIN_FRAC  = 12;
    localparam int MAX_STAGES = 32;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic signed [GAIN_W-1:0]  gain_t;
    typedef logic signed [OUT_W-1:0]   demod_t;

    localparam angle_t ANGLE_PI   = 16'sh8000;
    localparam angle_t ANGLE_ZERO = 16'sh0000;
    localparam gain_t  GAIN_RESET = 16'sd4096;
    localparam demod_t DEMOD_MAX  = 16'sh7FFF;
    localparam demod_t DEMOD_MIN  = 16'sh8000;

    // advance enable and item valid for one pipeline section
    typedef struct packed {
        logic en;
        logic valid;
    } stage_ctl_t;

    // round(atan(2^-k) * 32768 / pi)
    function automatic angle_t atan_unit(input int k);
        angle_t a;
        begin
            case (k)
                0:       a = 16'sd8192;
                1:       a = 16'sd4836;
                2:       a = 16'sd2555;
                3:       a = 16'sd1297;
                4:       a = 16'sd651;
                5:       a = 16'sd326;
                6:       a = 16'sd163;
                7:       a = 16'sd81;
                8:       a = 16'sd41;
                9:       a = 16'sd20;
                10:      a = 16'sd10;
                11:      a = 16'sd5;
                12:      a = 16'sd3;
                13:      a = 16'sd1;
                14:      a = 16'sd1;
                default: a = ANGLE_ZERO;
            endcase
            return a;
        end
    endfunction

endpackage

@@ rtl/core/fmqd_cordic.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// FM demodulator vectoring CORDIC
// Pipelined atan2: half-plane fold stage, then one register stage per
// micro-rotation. Angle in 16-bit units, 32768 = pi; zero vector gives 0.
// ---------------------------------------------------------------------------
module fmqd_cordic #(
    parameter int XW     = 36,
    parameter int STAGES = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fmqd_pkg::stage_ctl_t    ctl,
    input  logic signed [XW-1:0]    x_in,
    input  logic signed [XW-1:0]    y_in,
    output logic                    angle_valid,
    output fmqd_pkg::angle_t        angle
);

    logic signed [XW-1:0] x_reg     [0:STAGES];
    logic signed [XW-1:0] y_reg     [0:STAGES];
    fmqd_pkg::angle_t     z_reg     [0:STAGES];
    logic                 zero_reg  [0:STAGES];
    logic                 valid_reg [0:STAGES];

    logic signed [XW-1:0] x_fold;
    logic signed [XW-1:0] y_fold;
    fmqd_pkg::angle_t     z_fold;

    // left half-plane: negate vector, start at pi
    always_comb
    begin
        if (x_in < 0)
        begin
            x_fold = -x_in;
            y_fold = -y_in;
            z_fold = fmqd_pkg::ANGLE_PI;
        end
        else
        begin
            x_fold = x_in;
            y_fold = y_in;
            z_fold = fmqd_pkg::ANGLE_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (ctl.en)
        begin
            valid_reg[0] <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            x_reg[0]    <= x_fold;
            y_reg[0]    <= y_fold;
            z_reg[0]    <= z_fold;
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        logic signed [XW-1:0] x_next;
        logic signed [XW-1:0] y_next;
        fmqd_pkg::angle_t     z_next;

        always_comb
        begin
            if (!y_reg[k][XW-1])
            begin
                x_next = x_reg[k] + (y_reg[k] >>> k);
                y_next = y_reg[k] - (x_reg[k] >>> k);
                z_next = z_reg[k] + fmqd_pkg::atan_unit(k);
            end
            else
            begin
                x_next = x_reg[k] - (y_reg[k] >>> k);
                y_next = y_reg[k] + (x_reg[k] >>> k);
                z_next = z_reg[k] - fmqd_pkg::atan_unit(k);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (ctl.en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                x_reg[k+1]    <= x_next;
                y_reg[k+1]    <= y_next;
                z_reg[k+1]    <= z_next;
                zero_reg[k+1] <= zero_reg[k];
            end
        end
    end

    assign angle_valid = valid_reg[STAGES];
    assign angle       = zero_reg[STAGES] ? fmqd_pkg::ANGLE_ZERO : z_reg[STAGES];

    a_fold_positive: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] && !zero_reg[0] |-> !x_reg[0][XW-1])
        else $error("folded vector has negative x");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.en |=> $stable(valid_reg[STAGES]))
        else $error("CORDIC output valid moved during stall");

endmodule

@@ rtl/core/fm_quadrature_demodulator_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// FM quadrature demodulator
// Conjugate product of successive I/Q samples, pipelined CORDIC phase,
// gain scaling with saturation.
//
//   channel   | signals                                   | content
//   ----------+-------------------------------------------+-------------------
//   input     | s_axis_tvalid/tready/tdata                | sample_i, sample_q
//   output    | m_axis_tvalid/tready/tdata                | demod_out
//   config    | cfg_wr_en, cfg_wr_data                    | gain (Q3.12)
//
// One request per clock while s_axis_tready is high; registered steps in order
// are input, multiply, sum, fold, one stage per CORDIC rotation, gain, output.
// Reset: previous sample cleared to zero, gain to unity, pipeline empty.
// A stalled output fills a one-entry skid register; the pipeline then halts
// as a whole, so s_axis_tready follows only that register.
// ---------------------------------------------------------------------------
module fm_quadrature_demodulator_top #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [SW-1:0] sample_i, [2SW-1:SW] sample_q, zero padded to bytes
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [15:0] demod_out
    output logic [fmqd_pkg::OUT_W-1:0]            m_axis_tdata,
    input  logic                                  cfg_wr_en,
    input  logic [fmqd_pkg::GAIN_W-1:0]           cfg_wr_data
);

    localparam int SW          = SAMPLE_WIDTH;
    localparam int PROD_W      = 2 * SW;
    localparam int PROD_SHIFT  = (PROD_W > 60) ? (PROD_W - 60) : 0;
    localparam int PW          = PROD_W - PROD_SHIFT;
    localparam int SUM_W       = PW + 1;
    localparam int XW          = PW + 4;
    localparam int STAGE_LIMIT = (CORDIC_STAGES > fmqd_pkg::MAX_STAGES) ?
                                 fmqd_pkg::MAX_STAGES : CORDIC_STAGES;
    localparam int GMUL_W      = fmqd_pkg::GAIN_W + fmqd_pkg::ANGLE_W;

    logic                  pipe_en;
    logic                  s_accept;

    logic signed [SW-1:0]  sample_i;
    logic signed [SW-1:0]  sample_q;

    fmqd_pkg::gain_t       gain_reg;
    logic signed [SW-1:0]  prev_i_reg;
    logic signed [SW-1:0]  prev_q_reg;

    logic                  in_valid_reg;
    logic signed [SW-1:0]  cur_i_reg;
    logic signed [SW-1:0]  cur_q_reg;
    logic signed [SW-1:0]  old_i_reg;
    logic signed [SW-1:0]  old_q_reg;

    logic                  mul_valid_reg;
    logic signed [PROD_W-1:0] p_ii_reg;
    logic signed [PROD_W-1:0] p_qq_reg;
    logic signed [PROD_W-1:0] p_qi_reg;
    logic signed [PROD_W-1:0] p_iq_reg;

    logic signed [PROD_W-1:0] p_ii_sh;
    logic signed [PROD_W-1:0] p_qq_sh;
    logic signed [PROD_W-1:0] p_qi_sh;
    logic signed [PROD_W-1:0] p_iq_sh;
    logic signed [SUM_W-1:0]  re_next;
    logic signed [SUM_W-1:0]  im_next;

    logic                  sum_valid_reg;
    logic signed [SUM_W-1:0] re_reg;
    logic signed [SUM_W-1:0] im_reg;

    fmqd_pkg::stage_ctl_t  cordic_ctl;
    logic                  angle_valid;
    fmqd_pkg::angle_t      angle;

    logic                  gmul_valid_reg;
    logic signed [GMUL_W-1:0] gmul_reg;
    logic signed [GMUL_W-1:0] scaled;
    fmqd_pkg::demod_t      sat_out;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    fmqd_pkg::demod_t      out_data_reg;
    fmqd_pkg::demod_t      out_data_next;
    logic                  skid_valid_reg;
    logic                  skid_valid_next;
    fmqd_pkg::demod_t      skid_data_reg;
    fmqd_pkg::demod_t      skid_data_next;

    assign sample_i      = s_axis_tdata[SW-1:0];
    assign sample_q      = s_axis_tdata[2*SW-1:SW];
    assign pipe_en       = !skid_valid_reg;
    assign s_axis_tready = pipe_en;
    assign s_accept      = s_axis_tvalid && pipe_en;

    // configuration and previous sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= fmqd_pkg::GAIN_RESET;
            prev_i_reg <= '0;
            prev_q_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                gain_reg <= cfg_wr_data;
            end
            if (s_accept)
            begin
                prev_i_reg <= sample_i;
                prev_q_reg <= sample_q;
            end
        end
    end

    // shifted partial products and conjugate-product sums
    assign p_ii_sh = p_ii_reg >>> PROD_SHIFT;
    assign p_qq_sh = p_qq_reg >>> PROD_SHIFT;
    assign p_qi_sh = p_qi_reg >>> PROD_SHIFT;
    assign p_iq_sh = p_iq_reg >>> PROD_SHIFT;
    assign re_next = SUM_W'($signed(p_ii_sh[PW-1:0])) + SUM_W'($signed(p_qq_sh[PW-1:0]));
    assign im_next = SUM_W'($signed(p_qi_sh[PW-1:0])) - SUM_W'($signed(p_iq_sh[PW-1:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            in_valid_reg  <= s_axis_tvalid;
            mul_valid_reg <= in_valid_reg;
            sum_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            cur_i_reg <= sample_i;
            cur_q_reg <= sample_q;
            old_i_reg <= prev_i_reg;
            old_q_reg <= prev_q_reg;
            p_ii_reg  <= cur_i_reg * old_i_reg;
            p_qq_reg  <= cur_q_reg * old_q_reg;
            p_qi_reg  <= cur_q_reg * old_i_reg;
            p_iq_reg  <= cur_i_reg * old_q_reg;
            re_reg    <= re_next;
            im_reg    <= im_next;
        end
    end

    assign cordic_ctl.en    = pipe_en;
    assign cordic_ctl.valid = sum_valid_reg;

    fmqd_cordic #(
        .XW     (XW),
        .STAGES (STAGE_LIMIT)
    ) u_cordic (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (cordic_ctl),
        .x_in        (XW'(re_reg)),
        .y_in        (XW'(im_reg)),
        .angle_valid (angle_valid),
        .angle       (angle)
    );

    // gain multiply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gmul_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            gmul_valid_reg <= angle_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            gmul_reg <= gain_reg * angle;
        end
    end

    assign scaled = gmul_reg >>> fmqd_pkg::GAIN_FRAC;

    always_comb
    begin
        if ((scaled[GMUL_W-1:fmqd_pkg::OUT_W-1] == '0) ||
            (scaled[GMUL_W-1:fmqd_pkg::OUT_W-1] == '1))
        begin
            sat_out = scaled[fmqd_pkg::OUT_W-1:0];
        end
        else if (scaled[GMUL_W-1])
        begin
            sat_out = fmqd_pkg::DEMOD_MIN;
        end
        else
        begin
            sat_out = fmqd_pkg::DEMOD_MAX;
        end
    end

    // output register with skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (out_valid_reg && !m_axis_tready)
        begin
            if (gmul_valid_reg)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = sat_out;
            end
        end
        else
        begin
            out_valid_next = gmul_valid_reg;
            out_data_next  = sat_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready))
        else $error("skid filled without output stall");

    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(gmul_valid_reg) && $stable(gmul_reg))
        else $error("gain stage moved during stall");

    a_prev_update: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (prev_i_reg == $past(sample_i)) && (prev_q_reg == $past(sample_q)))
        else $error("previous sample not taken from accepted request");

endmodule
